// File: rtl/fqs_pkg.sv
// Shared types and codes for the searchable FIFO queue.
// No dependencies; used by fqs_cell, fqs_encode and the top level.
package fqs_pkg;

    localparam int DATA_W = 32;
    localparam int OUT_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTHEAD  = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

// File: rtl/fqs_cell.sv
// One storage cell of the queue chain: holds one entry, takes its neighbor's
// entry on a remove, and compares its entry against the search key.
// Depends on fqs_pkg.
module fqs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                              aclk,
    input  fqs_pkg::cell_ctl_t                ctl,
    input  logic [CW-1:0]                     count,
    input  logic signed [fqs_pkg::DATA_W-1:0] push_data,
    input  logic signed [fqs_pkg::DATA_W-1:0] next_entry,
    input  logic signed [fqs_pkg::DATA_W-1:0] key,
    output logic signed [fqs_pkg::DATA_W-1:0] entry,
    output logic                              match
);
    import fqs_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic                     occupied;
    logic                     is_tail;

    assign occupied = CW'(IDX) < count;
    assign is_tail  = CW'(IDX) == count;

    // A push and a remove never arrive together.
    always_ff @(posedge aclk) begin
        if (ctl.push && is_tail) begin
            entry_reg <= push_data;
        end else if (ctl.pop) begin
            entry_reg <= next_entry;
        end
    end

    assign entry = entry_reg;
    assign match = occupied && (entry_reg == key);

endmodule

// File: rtl/fqs_encode.sv
// First-match encoder: turns the registered match vector of the cell chain
// into the 1-based position of the lowest set bit, or 0 if none is set.
// Depends on fqs_pkg.
module fqs_encode #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic [DEPTH-1:0] match_vec,
    output logic [CW-1:0]    position
);
    import fqs_pkg::*;

    logic [DEPTH-1:0] first_hot;

    // Two's complement trick isolates the lowest set bit.
    assign first_hot = match_vec & (~match_vec + DEPTH'(1));

    always_comb begin
        logic [CW-1:0] idx;
        position = '0;
        for (int i = 0; i < DEPTH; i++) begin
            idx = CW'(i + 1);
            if (first_hot[i]) begin
                position = position | idx;
            end
        end
    end

endmodule

// File: rtl/fifo_queue_with_search_top.sv
// Searchable FIFO queue built as a chain of shifting cells.
// Pipeline: two register stages, st_* then out_*; m_valid rises when a result reaches out_*.
// Throughput: one request per cycle unless m_valid is held with m_ready low; every cell
// compares and shifts in the same cycle, and the first-match encoder sits in the second stage.
// Reset (aresetn, synchronous, active low) empties the queue and drops results
// in flight; stored entries are not cleared, the fill count masks them.
module fifo_queue_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [fqs_pkg::DATA_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [fqs_pkg::OUT_W-1:0]         m_position,
    output logic [fqs_pkg::OUT_W-1:0]         m_count,
    output logic                              m_is_full,
    output logic                              m_is_empty
);
    import fqs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                     advance;
    logic                     accept;
    opcode_t                  op;
    logic                     is_full;
    logic                     is_empty;
    logic                     do_push;
    logic                     do_pop;
    cell_ctl_t                ctl;
    status_t                  status_s1;
    logic signed [DATA_W-1:0] entry_w [DEPTH];
    logic [DEPTH-1:0]         match_w;
    logic [CW-1:0]            pos_w;

    logic [CW-1:0]    count_reg,    count_next;
    logic             st_valid_reg;
    status_t          st_status_reg;
    logic             st_find_reg;
    logic [DEPTH-1:0] st_match_reg;
    logic [CW-1:0]    st_count_reg;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [OUT_W-1:0]     out_pos_reg;
    logic [OUT_W-1:0]     out_count_reg;
    logic                 out_full_reg;
    logic                 out_empty_reg;
    logic [CW+OUT_W-1:0]  pos_ext;
    logic [CW+OUT_W-1:0]  count_ext;
    status_t              status_s2;

    // Both stages move together whenever the output register can take a result.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;
    assign op      = opcode_t'(s_opcode);

    assign is_full  = count_reg == CW'(DEPTH);
    assign is_empty = count_reg == '0;

    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        status_s1  = ST_OK;
        count_next = count_reg;
        case (op)
            OP_PUSH: begin
                if (is_full) begin
                    status_s1 = ST_FULL;
                end else begin
                    do_push    = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (is_empty) begin
                    status_s1 = ST_EMPTY;
                end else if (!match_w[0]) begin
                    status_s1 = ST_NOTHEAD;
                end else begin
                    do_pop     = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_FIND: status_s1 = ST_OK;
            OP_NOP:  status_s1 = ST_OK;
            default: status_s1 = ST_OK;
        endcase
    end

    assign ctl.push = do_push;
    assign ctl.pop  = do_pop;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] next_w;
        if (i == DEPTH - 1) begin : g_last
            assign next_w = entry_w[i];
        end else begin : g_mid
            assign next_w = entry_w[i+1];
        end
        fqs_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .count      (count_reg),
            .push_data  (s_value),
            .next_entry (next_w),
            .key        (s_value),
            .entry      (entry_w[i]),
            .match      (match_w[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (advance) begin
                st_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st_status_reg <= status_s1;
            st_find_reg   <= op == OP_FIND;
            st_match_reg  <= match_w;
            st_count_reg  <= count_next;
        end
    end

    fqs_encode #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_encode (
        .match_vec (st_match_reg),
        .position  (pos_w)
    );

    always_comb begin
        status_s2 = st_status_reg;
        pos_ext   = '0;
        if (st_find_reg) begin
            pos_ext = {{OUT_W{1'b0}}, pos_w};
            if (pos_w == '0) begin
                status_s2 = ST_NOTFOUND;
            end
        end
    end

    assign count_ext = {{OUT_W{1'b0}}, st_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= status_s2;
            out_pos_reg    <= pos_ext[OUT_W-1:0];
            out_count_reg  <= count_ext[OUT_W-1:0];
            out_full_reg   <= st_count_reg == CW'(DEPTH);
            out_empty_reg  <= st_count_reg == '0;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_status   = out_status_reg;
    assign m_position = out_pos_reg;
    assign m_count    = out_count_reg;
    assign m_is_full  = out_full_reg;
    assign m_is_empty = out_empty_reg;

    // The fill count never runs past the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // An accepted push into a queue with room grows it by exactly one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the queue by one");

    // A remove only shifts the chain when the head is occupied.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> !is_empty && !do_push)
        else $error("remove issued on an empty queue");

    // Only a successful find reports a position.
    a_pos_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != ST_OK |-> out_pos_reg == '0)
        else $error("position reported with a failing status");

endmodule
